FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle; off while in reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Delayed form of the implication above; off while in reset.
`define ASSERT_DLY3(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##3 (cons)) \
    else $error("assertion failed: delayed implication");

`endif

FILE: hw/rtl/resa_pkg.sv
`default_nettype none

package resa_pkg;

  // Validity windows of the sensor readings and the fixed flow limit.
  localparam int SPEED_VALID_MIN = 0;
  localparam int SPEED_VALID_MAX = 65535;
  localparam int EGT_VALID_MIN   = -2048;
  localparam int EGT_VALID_MAX   = 2047;
  localparam int FLOW_WARN_LIMIT = 50;

  localparam logic [15:0] FUEL_MISSING = 16'hFFFF;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    PHASE_OFF    = 2'd0,
    PHASE_START  = 2'd1,
    PHASE_STABLE = 2'd2,
    PHASE_STOP   = 2'd3
  } resa_phase_e;

  typedef enum logic [1:0] {
    LVL_INFO  = 2'd0,
    LVL_WARN  = 2'd1,
    LVL_FATAL = 2'd2
  } resa_level_e;

  typedef enum logic [2:0] {
    REG_SPEED_WARN  = 3'd0,
    REG_SPEED_FATAL = 3'd1,
    REG_EGT_ST_WARN = 3'd2,
    REG_EGT_ST_FAT  = 3'd3,
    REG_EGT_RN_WARN = 3'd4,
    REG_EGT_RN_FAT  = 3'd5,
    REG_FUEL_LOW    = 3'd6,
    REG_FUEL_CRIT   = 3'd7
  } resa_reg_e;

  // Alert mask bit positions.
  localparam int MB_SPD_ONE     = 0;
  localparam int MB_EGT_ONE     = 1;
  localparam int MB_SPD_PAIR    = 2;
  localparam int MB_EGT_PAIR    = 3;
  localparam int MB_SPD_BOTH    = 4;
  localparam int MB_EGT_BOTH    = 5;
  localparam int MB_FUEL_LOW    = 6;
  localparam int MB_FUEL_CRIT   = 7;
  localparam int MB_FLOW_HIGH   = 8;
  localparam int MB_SPD_WARN    = 9;
  localparam int MB_SPD_FATAL   = 10;
  localparam int MB_EGT_ST_WARN = 11;
  localparam int MB_EGT_ST_FAT  = 12;
  localparam int MB_EGT_RN_WARN = 13;
  localparam int MB_EGT_RN_FAT  = 14;
  localparam int MASK_W         = 15;

  typedef struct packed {
    logic [1:0]         engine_phase;
    logic [15:0]        speed_left_a;
    logic [15:0]        speed_left_b;
    logic [15:0]        speed_right_a;
    logic [15:0]        speed_right_b;
    logic signed [11:0] egt_left_a;
    logic signed [11:0] egt_left_b;
    logic signed [11:0] egt_right_a;
    logic signed [11:0] egt_right_b;
    logic [15:0]        fuel_left;
    logic [7:0]         fuel_rate;
  } resa_req_t;

  typedef struct packed {
    logic [MASK_W-1:0]  alert_mask;
    logic [15:0]        fused_speed_left;
    logic [15:0]        fused_speed_right;
    logic signed [11:0] fused_egt_left;
    logic signed [11:0] fused_egt_right;
    logic [1:0]         speed_left_level;
    logic [1:0]         speed_right_level;
    logic [1:0]         egt_left_level;
    logic [1:0]         egt_right_level;
    logic [1:0]         fuel_level_state;
    logic               flow_level_state;
  } resa_rsp_t;

  typedef struct packed {
    logic [15:0]        speed_warn;
    logic [15:0]        speed_fatal;
    logic signed [11:0] egt_start_warn;
    logic signed [11:0] egt_start_fatal;
    logic signed [11:0] egt_stable_warn;
    logic signed [11:0] egt_stable_fatal;
    logic [15:0]        fuel_low;
    logic [15:0]        fuel_critical;
  } resa_cfg_t;

  // Fuse stage result.
  typedef struct packed {
    logic [1:0]         phase;
    logic [15:0]        fsl;
    logic [15:0]        fsr;
    logic signed [11:0] fel;
    logic signed [11:0] fer;
    logic               vsl;
    logic               vsr;
    logic               vel;
    logic               ver;
    logic               spd_one_bad;
    logic               egt_one_bad;
    logic [15:0]        fuel;
    logic [7:0]         flow;
  } resa_fuse_t;

  // Compare stage result.
  typedef struct packed {
    logic [1:0]         phase;
    logic [15:0]        fsl;
    logic [15:0]        fsr;
    logic signed [11:0] fel;
    logic signed [11:0] fer;
    logic               vsl;
    logic               vsr;
    logic               vel;
    logic               ver;
    logic               spd_one_bad;
    logic               egt_one_bad;
    logic               fuel_missing;
    logic               fuel_low;
    logic               fuel_crit;
    logic               flow_high;
    logic               sl_warn;
    logic               sl_fatal;
    logic               sr_warn;
    logic               sr_fatal;
    logic               el_st_warn;
    logic               el_st_fatal;
    logic               er_st_warn;
    logic               er_st_fatal;
    logic               el_rn_warn;
    logic               el_rn_fatal;
    logic               er_rn_warn;
    logic               er_rn_fatal;
  } resa_chk_t;

  function automatic logic spd_ok(logic [15:0] v);
    return (int'(v) >= SPEED_VALID_MIN) && (int'(v) <= SPEED_VALID_MAX);
  endfunction

  function automatic logic egt_ok(logic signed [11:0] v);
    return (int'(v) >= EGT_VALID_MIN) && (int'(v) <= EGT_VALID_MAX);
  endfunction

  function automatic logic [1:0] grade(logic ok, logic over_warn, logic over_fatal);
    resa_level_e lvl;
    if (!ok || over_fatal) begin
      lvl = LVL_FATAL;
    end else if (over_warn) begin
      lvl = LVL_WARN;
    end else begin
      lvl = LVL_INFO;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/resa_cfg_regs.sv
`default_nettype none

module resa_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [resa_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [resa_pkg::PDATA_W-1:0]  pwdata_i,
  output logic      [resa_pkg::PDATA_W-1:0]  prdata_o,
  output resa_pkg::resa_cfg_t                cfg_o
);

  resa_pkg::resa_cfg_t cfg_q, cfg_d;
  resa_pkg::resa_reg_e sel;
  logic                wr_en;

  assign sel   = resa_pkg::resa_reg_e'(paddr_i[4:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        resa_pkg::REG_SPEED_WARN:  cfg_d.speed_warn       = pwdata_i[15:0];
        resa_pkg::REG_SPEED_FATAL: cfg_d.speed_fatal      = pwdata_i[15:0];
        resa_pkg::REG_EGT_ST_WARN: cfg_d.egt_start_warn   = pwdata_i[11:0];
        resa_pkg::REG_EGT_ST_FAT:  cfg_d.egt_start_fatal  = pwdata_i[11:0];
        resa_pkg::REG_EGT_RN_WARN: cfg_d.egt_stable_warn  = pwdata_i[11:0];
        resa_pkg::REG_EGT_RN_FAT:  cfg_d.egt_stable_fatal = pwdata_i[11:0];
        resa_pkg::REG_FUEL_LOW:    cfg_d.fuel_low         = pwdata_i[15:0];
        resa_pkg::REG_FUEL_CRIT:   cfg_d.fuel_critical    = pwdata_i[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      resa_pkg::REG_SPEED_WARN:  prdata_o = {16'b0, cfg_q.speed_warn};
      resa_pkg::REG_SPEED_FATAL: prdata_o = {16'b0, cfg_q.speed_fatal};
      resa_pkg::REG_EGT_ST_WARN: prdata_o = 32'(cfg_q.egt_start_warn);
      resa_pkg::REG_EGT_ST_FAT:  prdata_o = 32'(cfg_q.egt_start_fatal);
      resa_pkg::REG_EGT_RN_WARN: prdata_o = 32'(cfg_q.egt_stable_warn);
      resa_pkg::REG_EGT_RN_FAT:  prdata_o = 32'(cfg_q.egt_stable_fatal);
      resa_pkg::REG_FUEL_LOW:    prdata_o = {16'b0, cfg_q.fuel_low};
      resa_pkg::REG_FUEL_CRIT:   prdata_o = {16'b0, cfg_q.fuel_critical};
      default:                   prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_warn       <= 16'hFFFF;
      cfg_q.speed_fatal      <= 16'hFFFF;
      cfg_q.egt_start_warn   <= 12'sh7FF;
      cfg_q.egt_start_fatal  <= 12'sh7FF;
      cfg_q.egt_stable_warn  <= 12'sh7FF;
      cfg_q.egt_stable_fatal <= 12'sh7FF;
      cfg_q.fuel_low         <= 16'h0000;
      cfg_q.fuel_critical    <= 16'h0000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/resa_fuse.sv
`default_nettype none

module resa_fuse (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire resa_pkg::resa_req_t  req_i,
  output logic                      valid_o,
  output resa_pkg::resa_fuse_t      fuse_o
);

  resa_pkg::resa_fuse_t fuse_d, fuse_q;
  logic                 valid_q;
  logic                 ok_sla, ok_slb, ok_sra, ok_srb;
  logic                 ok_ela, ok_elb, ok_era, ok_erb;
  logic [16:0]          sum_sl, sum_sr;
  logic signed [12:0]   sum_el, sum_er;

  always_comb begin
    ok_sla = resa_pkg::spd_ok(req_i.speed_left_a);
    ok_slb = resa_pkg::spd_ok(req_i.speed_left_b);
    ok_sra = resa_pkg::spd_ok(req_i.speed_right_a);
    ok_srb = resa_pkg::spd_ok(req_i.speed_right_b);
    ok_ela = resa_pkg::egt_ok(req_i.egt_left_a);
    ok_elb = resa_pkg::egt_ok(req_i.egt_left_b);
    ok_era = resa_pkg::egt_ok(req_i.egt_right_a);
    ok_erb = resa_pkg::egt_ok(req_i.egt_right_b);

    // Full-width sums; dropping bit 0 halves toward minus infinity.
    sum_sl = {1'b0, req_i.speed_left_a} + {1'b0, req_i.speed_left_b};
    sum_sr = {1'b0, req_i.speed_right_a} + {1'b0, req_i.speed_right_b};
    sum_el = {req_i.egt_left_a[11], req_i.egt_left_a}
           + {req_i.egt_left_b[11], req_i.egt_left_b};
    sum_er = {req_i.egt_right_a[11], req_i.egt_right_a}
           + {req_i.egt_right_b[11], req_i.egt_right_b};

    fuse_d.phase = req_i.engine_phase;
    fuse_d.fuel  = req_i.fuel_left;
    fuse_d.flow  = req_i.fuel_rate;
    fuse_d.vsl   = ok_sla || ok_slb;
    fuse_d.vsr   = ok_sra || ok_srb;
    fuse_d.vel   = ok_ela || ok_elb;
    fuse_d.ver   = ok_era || ok_erb;
    fuse_d.spd_one_bad = !(ok_sla && ok_slb && ok_sra && ok_srb);
    fuse_d.egt_one_bad = !(ok_ela && ok_elb && ok_era && ok_erb);

    fuse_d.fsl = (ok_sla && ok_slb) ? sum_sl[16:1] :
                 ok_sla ? req_i.speed_left_a : ok_slb ? req_i.speed_left_b : 16'd0;
    fuse_d.fsr = (ok_sra && ok_srb) ? sum_sr[16:1] :
                 ok_sra ? req_i.speed_right_a : ok_srb ? req_i.speed_right_b : 16'd0;
    fuse_d.fel = (ok_ela && ok_elb) ? sum_el[12:1] :
                 ok_ela ? req_i.egt_left_a : ok_elb ? req_i.egt_left_b : 12'sd0;
    fuse_d.fer = (ok_era && ok_erb) ? sum_er[12:1] :
                 ok_era ? req_i.egt_right_a : ok_erb ? req_i.egt_right_b : 12'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      fuse_q <= fuse_d;
    end
  end

  assign valid_o = valid_q;
  assign fuse_o  = fuse_q;

endmodule

`default_nettype wire

FILE: hw/rtl/resa_check.sv
`default_nettype none

module resa_check (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire resa_pkg::resa_fuse_t fuse_i,
  input  wire resa_pkg::resa_cfg_t  cfg_i,
  output logic                      valid_o,
  output resa_pkg::resa_chk_t       chk_o
);

  resa_pkg::resa_chk_t chk_d, chk_q;
  logic                valid_q;

  always_comb begin
    chk_d.phase       = fuse_i.phase;
    chk_d.fsl         = fuse_i.fsl;
    chk_d.fsr         = fuse_i.fsr;
    chk_d.fel         = fuse_i.fel;
    chk_d.fer         = fuse_i.fer;
    chk_d.vsl         = fuse_i.vsl;
    chk_d.vsr         = fuse_i.vsr;
    chk_d.vel         = fuse_i.vel;
    chk_d.ver         = fuse_i.ver;
    chk_d.spd_one_bad = fuse_i.spd_one_bad;
    chk_d.egt_one_bad = fuse_i.egt_one_bad;

    chk_d.fuel_missing = (fuse_i.fuel == resa_pkg::FUEL_MISSING);
    chk_d.fuel_low     = (fuse_i.fuel < cfg_i.fuel_low);
    chk_d.fuel_crit    = (fuse_i.fuel < cfg_i.fuel_critical);
    chk_d.flow_high    = (fuse_i.flow > 8'(resa_pkg::FLOW_WARN_LIMIT));

    // Raw threshold compares; validity is folded in at the grade stage.
    chk_d.sl_warn     = (fuse_i.fsl > cfg_i.speed_warn);
    chk_d.sl_fatal    = (fuse_i.fsl > cfg_i.speed_fatal);
    chk_d.sr_warn     = (fuse_i.fsr > cfg_i.speed_warn);
    chk_d.sr_fatal    = (fuse_i.fsr > cfg_i.speed_fatal);
    chk_d.el_st_warn  = (fuse_i.fel > cfg_i.egt_start_warn);
    chk_d.el_st_fatal = (fuse_i.fel > cfg_i.egt_start_fatal);
    chk_d.er_st_warn  = (fuse_i.fer > cfg_i.egt_start_warn);
    chk_d.er_st_fatal = (fuse_i.fer > cfg_i.egt_start_fatal);
    chk_d.el_rn_warn  = (fuse_i.fel > cfg_i.egt_stable_warn);
    chk_d.el_rn_fatal = (fuse_i.fel > cfg_i.egt_stable_fatal);
    chk_d.er_rn_warn  = (fuse_i.fer > cfg_i.egt_stable_warn);
    chk_d.er_rn_fatal = (fuse_i.fer > cfg_i.egt_stable_fatal);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      chk_q <= chk_d;
    end
  end

  assign valid_o = valid_q;
  assign chk_o   = chk_q;

endmodule

`default_nettype wire

FILE: hw/rtl/resa_grade.sv
`default_nettype none

module resa_grade (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire resa_pkg::resa_chk_t  chk_i,
  output logic                      valid_o,
  output resa_pkg::resa_rsp_t       rsp_o
);

  resa_pkg::resa_rsp_t rsp_d, rsp_q;
  logic                valid_q;
  logic                ph_start, ph_stable;
  logic [resa_pkg::MASK_W-1:0] mask;

  always_comb begin
    ph_start  = (chk_i.phase == resa_pkg::PHASE_START);
    ph_stable = (chk_i.phase == resa_pkg::PHASE_STABLE);

    mask = '0;
    mask[resa_pkg::MB_SPD_ONE]   = chk_i.spd_one_bad;
    mask[resa_pkg::MB_EGT_ONE]   = chk_i.egt_one_bad;
    mask[resa_pkg::MB_SPD_PAIR]  = !chk_i.vsl || !chk_i.vsr;
    mask[resa_pkg::MB_EGT_PAIR]  = !chk_i.vel || !chk_i.ver;
    mask[resa_pkg::MB_SPD_BOTH]  = !chk_i.vsl && !chk_i.vsr;
    mask[resa_pkg::MB_EGT_BOTH]  = !chk_i.vel && !chk_i.ver;
    mask[resa_pkg::MB_FUEL_LOW]  = !chk_i.fuel_missing && chk_i.fuel_low;
    mask[resa_pkg::MB_FUEL_CRIT] = !chk_i.fuel_missing && chk_i.fuel_crit;
    mask[resa_pkg::MB_FLOW_HIGH] = chk_i.flow_high;
    mask[resa_pkg::MB_SPD_WARN]  = (chk_i.vsl && chk_i.sl_warn) || (chk_i.vsr && chk_i.sr_warn);
    mask[resa_pkg::MB_SPD_FATAL] = (chk_i.vsl && chk_i.sl_fatal) ||
                                   (chk_i.vsr && chk_i.sr_fatal);
    mask[resa_pkg::MB_EGT_ST_WARN] = ph_start &&
      ((chk_i.vel && chk_i.el_st_warn) || (chk_i.ver && chk_i.er_st_warn));
    mask[resa_pkg::MB_EGT_ST_FAT]  = ph_start &&
      ((chk_i.vel && chk_i.el_st_fatal) || (chk_i.ver && chk_i.er_st_fatal));
    mask[resa_pkg::MB_EGT_RN_WARN] = ph_stable &&
      ((chk_i.vel && chk_i.el_rn_warn) || (chk_i.ver && chk_i.er_rn_warn));
    mask[resa_pkg::MB_EGT_RN_FAT]  = ph_stable &&
      ((chk_i.vel && chk_i.el_rn_fatal) || (chk_i.ver && chk_i.er_rn_fatal));

    rsp_d.alert_mask        = mask;
    rsp_d.fused_speed_left  = chk_i.fsl;
    rsp_d.fused_speed_right = chk_i.fsr;
    rsp_d.fused_egt_left    = chk_i.fel;
    rsp_d.fused_egt_right   = chk_i.fer;
    rsp_d.speed_left_level  = resa_pkg::grade(chk_i.vsl, chk_i.sl_warn, chk_i.sl_fatal);
    rsp_d.speed_right_level = resa_pkg::grade(chk_i.vsr, chk_i.sr_warn, chk_i.sr_fatal);
    rsp_d.egt_left_level    = resa_pkg::grade(chk_i.vel, chk_i.el_rn_warn, chk_i.el_rn_fatal);
    rsp_d.egt_right_level   = resa_pkg::grade(chk_i.ver, chk_i.er_rn_warn, chk_i.er_rn_fatal);
    // Missing fuel counts as critical.
    rsp_d.fuel_level_state  = resa_pkg::grade(!chk_i.fuel_missing, chk_i.fuel_low,
                                              chk_i.fuel_crit);
    rsp_d.flow_level_state  = chk_i.flow_high;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/redundant_engine_sensor_alerter_unit.sv
`default_nettype none
// Redundant engine sensor alerter.
// Request channel: drive one sensor snapshot on req_i and pulse start; the
// request is taken at every rising edge with start high and busy low. busy
// stays low, so a new snapshot may be issued in every cycle.
// Result channel: result_valid_o is high for exactly one cycle per request,
// with the fused readings, six levels and the 15-bit alert mask on result_o.
// The result is registered through the fuse, compare and grade stages, one
// register each; throughput is one request per cycle, set by the
// three-stage pipeline with no shared unit.
// The receiver cannot stall: every result is shown for one cycle only and
// must be captured then.
// Limits sit in eight 32-bit registers behind an APB-style port, register i
// at byte address 4*i; write them only while no request is in flight.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the limit
// registers with their reset values: speed and temperature limits at their
// maxima, fuel limits at zero.

module redundant_engine_sensor_alerter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire resa_pkg::resa_req_t           req_i,
  // result channel
  output logic                               result_valid_o,
  output resa_pkg::resa_rsp_t                result_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [resa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [resa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [resa_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  resa_pkg::resa_cfg_t  cfg;
  resa_pkg::resa_fuse_t fuse;
  resa_pkg::resa_chk_t  chk;
  logic                 req_take;
  logic                 fuse_vld;
  logic                 chk_vld;

  // The pipeline never backs up, so every start is taken.
  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign req_take = start && !busy;

  resa_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite && pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Stage 1: validate each reading and fuse the pairs.
  resa_fuse u_fuse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_take),
    .req_i   (req_i),
    .valid_o (fuse_vld),
    .fuse_o  (fuse)
  );

  // Stage 2: compare fused values, fuel and flow against the limits.
  resa_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fuse_vld),
    .fuse_i  (fuse),
    .cfg_i   (cfg),
    .valid_o (chk_vld),
    .chk_o   (chk)
  );

  // Stage 3: gate by validity and phase, build mask and levels.
  resa_grade u_grade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chk_vld),
    .chk_i   (chk),
    .valid_o (result_valid_o),
    .rsp_o   (result_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/resa_checker.sv
`default_nettype none
`include "assert_macros.svh"

module resa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                result_valid_i,
  input wire resa_pkg::resa_rsp_t result_i
);

  logic take;
  logic spd_both;
  logic spd_pair;
  logic left_dead;

  assign take      = start && !busy;
  assign spd_both  = result_valid_i && result_i.alert_mask[resa_pkg::MB_SPD_BOTH];
  assign spd_pair  = result_i.alert_mask[resa_pkg::MB_SPD_PAIR];
  assign left_dead = (result_i.fused_speed_left == 16'd0) &&
                     (result_i.speed_left_level == resa_pkg::LVL_FATAL);

  // Every request yields a result after the fuse, compare and grade registers, and no result comes without one.
  `ASSERT_DLY3(a_result_follows, clk_i, rst_ni, take, result_valid_i)
  `ASSERT_DLY3(a_no_spurious, clk_i, rst_ni, !take, !result_valid_i)
  // Losing both speed pairs implies losing one pair.
  `ASSERT_IMP(a_speed_both_pair, clk_i, rst_ni, spd_both, spd_pair)
  // With both speed pairs invalid, the left pair reports zero speed at fatal level.
  `ASSERT_IMP(a_speed_inv_left, clk_i, rst_ni, spd_both, left_dead)

endmodule

bind redundant_engine_sensor_alerter_unit resa_checker u_resa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);

`default_nettype wire
